// ----- hw/rtl/cmsk_pkg.sv -----
// Count-min sketch package: geometry, hash constants, state and table request types.
// No dependencies; imported by every module of the sketch core.
`default_nettype none

package cmsk_pkg;

	localparam int COLUMNS = 1024;
	localparam int ROWS    = 4;

	localparam int KEY_W = 64;
	localparam int CNT_W = 64;

	localparam int COL_W     = $clog2(COLUMNS);
	localparam int COL_WP    = COL_W + 1;
	localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int ADDR_W    = ROW_W + COL_W;
	localparam int TBL_DEPTH = 1 << ADDR_W;
	localparam bit COL_POW2  = ((COLUMNS & (COLUMNS - 1)) == 0);

	localparam int MOD_BITS   = 4;
	localparam int MOD_DIGITS = KEY_W / MOD_BITS;
	localparam int MOD_CNT_W  = $clog2(MOD_DIGITS);

	localparam logic [COL_W:0] COLS_WIDE = COL_WP'(COLUMNS);

	localparam logic [KEY_W-1:0] ROW_SALT  = 64'h94d0_49bb_1331_11eb;
	localparam logic [KEY_W-1:0] MIX_MUL_A = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [KEY_W-1:0] MIX_MUL_B = 64'h94d0_49bb_1331_11eb;

	localparam logic [CNT_W-1:0] CNT_ALL_ONES = '1;

	localparam logic MODE_ADD = 1'b0;
	localparam logic MODE_EST = 1'b1;

	typedef enum logic [2:0] {
		C_CLEAR,
		C_IDLE,
		C_ISSUE,
		C_HASH,
		C_UPDATE
	} core_state_t;

	typedef enum logic [2:0] {
		H_IDLE,
		H_MUL0,
		H_MUL1,
		H_MUL2,
		H_SHIFT,
		H_MOD
	} hash_state_t;

	typedef struct packed {
		logic              re;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [CNT_W-1:0]  wdata;
	} tbl_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cmsk_table.sv -----
// Counter table: single-port synchronous RAM of 2^(ROW_W+COL_W) counters, read data registered.
// Depends on cmsk_pkg for geometry and the request struct.
`default_nettype none

module cmsk_table (
	input  logic                    clk,
	input  cmsk_pkg::tbl_req_t      req,
	output logic [cmsk_pkg::CNT_W-1:0] rdata
);
	import cmsk_pkg::*;

	logic [CNT_W-1:0] mem_q [TBL_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem_q[req.addr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/cmsk_hash.sv -----
// Row hash unit: mixes a salted key with one shared 32x32 multiplier and reduces to a column.
// Depends on cmsk_pkg for constants and the hash state type.
`default_nettype none

module cmsk_hash (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [cmsk_pkg::KEY_W-1:0] seed,
	output logic                       done,
	output logic [cmsk_pkg::COL_W-1:0] col
);
	import cmsk_pkg::*;

	hash_state_t st_q, st_d;

	logic [KEY_W-1:0]     x_q, x_d;
	logic [KEY_W-1:0]     acc_q, acc_d;
	logic                 pass_q, pass_d;
	logic [MOD_CNT_W-1:0] cnt_q, cnt_d;
	logic [COL_W-1:0]     rem_q, rem_d;
	logic [COL_W-1:0]     col_q, col_d;
	logic                 done_q, done_d;

	logic [KEY_W-1:0]     mix_c;
	logic [31:0]          mul_a, mul_b;
	logic [63:0]          mul_p;
	logic [COL_W:0]       rem_w;
	logic [COL_W-1:0]     rem_t;
	logic [COL_W-1:0]     rem_nx;

	assign mix_c = pass_q ? MIX_MUL_B : MIX_MUL_A;
	assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

	// remainder by COLUMNS, one digit of MOD_BITS hash bits per cycle, msb first
	always_comb begin
		rem_t = rem_q;
		rem_w = '0;
		for (int i = 0; i < MOD_BITS; i++) begin
			rem_w = {rem_t, x_q[KEY_W-1-i]};
			if (rem_w >= COLS_WIDE) begin
				rem_w = rem_w - COLS_WIDE;
			end
			rem_t = rem_w[COL_W-1:0];
		end
		rem_nx = rem_t;
	end

	always_comb begin
		st_d   = st_q;
		x_d    = x_q;
		acc_d  = acc_q;
		pass_d = pass_q;
		cnt_d  = cnt_q;
		rem_d  = rem_q;
		col_d  = col_q;
		done_d = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		unique case (st_q)
			H_IDLE: begin
				if (go) begin
					x_d    = seed ^ (seed >> 30);
					pass_d = 1'b0;
					st_d   = H_MUL0;
				end
			end
			H_MUL0: begin
				mul_a = x_q[31:0];
				mul_b = mix_c[31:0];
				acc_d = mul_p;
				st_d  = H_MUL1;
			end
			H_MUL1: begin
				mul_a = x_q[63:32];
				mul_b = mix_c[31:0];
				acc_d[63:32] = acc_q[63:32] + mul_p[31:0];
				st_d  = H_MUL2;
			end
			H_MUL2: begin
				mul_a = x_q[31:0];
				mul_b = mix_c[63:32];
				acc_d[63:32] = acc_q[63:32] + mul_p[31:0];
				st_d  = H_SHIFT;
			end
			H_SHIFT: begin
				if (!pass_q) begin
					x_d    = acc_q ^ (acc_q >> 27);
					pass_d = 1'b1;
					st_d   = H_MUL0;
				end else begin
					x_d = acc_q ^ (acc_q >> 31);
					if (COL_POW2) begin
						col_d  = x_d[COL_W-1:0];
						done_d = 1'b1;
						st_d   = H_IDLE;
					end else begin
						rem_d = '0;
						cnt_d = '0;
						st_d  = H_MOD;
					end
				end
			end
			H_MOD: begin
				x_d   = x_q << MOD_BITS;
				rem_d = rem_nx;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == MOD_CNT_W'(MOD_DIGITS - 1)) begin
					col_d  = rem_nx;
					done_d = 1'b1;
					st_d   = H_IDLE;
				end
			end
			default: begin
				st_d = H_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= H_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		x_q    <= x_d;
		acc_q  <= acc_d;
		pass_q <= pass_d;
		cnt_q  <= cnt_d;
		rem_q  <= rem_d;
		col_q  <= col_d;
	end

	assign done = done_q;
	assign col  = col_q;

endmodule

`default_nettype wire

// ----- hw/rtl/count_min_sketch_core.sv -----
// Count-min sketch core: command port, row sequencer, read-modify-write of the counter table.
// Depends on cmsk_pkg, cmsk_hash and cmsk_table.
`default_nettype none

// After reset the core clears all 2^(ROW_W+COL_W) table entries, one per cycle, with busy
// high. A command is taken when start is high and busy is low; busy then stays high while
// the rows are visited one after another. For each row the hash runs each of its two 64-bit
// multiplies as three passes through one 32x32 multiplier, a non-power-of-two COLUMNS adds a
// remainder loop, and the row ends with a read and, for an add, a write of the single-port
// table. An estimate returns its beat on estimate_value with done high for exactly one cycle,
// in the first cycle that busy is low again; there is no back-pressure, so the receiver must
// take it then. An add returns nothing. Counters wrap modulo 2^64; an all-ones minimum reads
// as zero.
module count_min_sketch_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       mode,
	input  logic [cmsk_pkg::KEY_W-1:0] key,
	input  logic [cmsk_pkg::CNT_W-1:0] amount,
	output logic                       done,
	output logic [cmsk_pkg::CNT_W-1:0] estimate_value
);
	import cmsk_pkg::*;

	core_state_t st_q, st_d;

	logic [ADDR_W-1:0] clr_q;
	logic              done_q, done_d;

	logic              mode_q;
	logic [KEY_W-1:0]  key_q;
	logic [CNT_W-1:0]  amount_q;
	logic [KEY_W-1:0]  salt_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CNT_W-1:0]  least_q;
	logic [CNT_W-1:0]  est_q;

	logic              hash_go;
	logic              hash_done;
	logic [COL_W-1:0]  hash_col;
	tbl_req_t          req;
	logic [CNT_W-1:0]  rdata;
	logic [CNT_W-1:0]  least_new;
	logic              row_last;

	cmsk_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (hash_go),
		.seed   (key_q ^ salt_q),
		.done   (hash_done),
		.col    (hash_col)
	);

	cmsk_table u_table (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	assign least_new = (rdata < least_q) ? rdata : least_q;
	assign row_last  = (row_q == ROW_W'(ROWS - 1));

	always_comb begin
		st_d    = st_q;
		hash_go = 1'b0;
		done_d  = 1'b0;
		req     = '0;
		unique case (st_q)
			C_CLEAR: begin
				req.we    = 1'b1;
				req.addr  = clr_q;
				req.wdata = '0;
				if (clr_q == '1) begin
					st_d = C_IDLE;
				end
			end
			C_IDLE: begin
				if (start) begin
					st_d = C_ISSUE;
				end
			end
			C_ISSUE: begin
				hash_go = 1'b1;
				st_d    = C_HASH;
			end
			C_HASH: begin
				if (hash_done) begin
					req.re   = 1'b1;
					req.addr = {row_q, hash_col};
					st_d     = C_UPDATE;
				end
			end
			C_UPDATE: begin
				req.we    = (mode_q == MODE_ADD);
				req.addr  = addr_q;
				req.wdata = rdata + amount_q;
				if (row_last) begin
					done_d = (mode_q == MODE_EST);
					st_d   = C_IDLE;
				end else begin
					st_d = C_ISSUE;
				end
			end
			default: begin
				st_d = C_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= C_CLEAR;
			clr_q  <= '0;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= done_d;
			if (st_q == C_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == C_IDLE && start) begin
			mode_q   <= mode;
			key_q    <= key;
			amount_q <= amount;
			salt_q   <= '0;
			row_q    <= '0;
			least_q  <= CNT_ALL_ONES;
		end
		if (st_q == C_HASH && hash_done) begin
			addr_q <= {row_q, hash_col};
		end
		if (st_q == C_UPDATE) begin
			least_q <= least_new;
			row_q   <= row_q + 1'b1;
			salt_q  <= salt_q + ROW_SALT;
			if (row_last && mode_q == MODE_EST) begin
				est_q <= (least_new == CNT_ALL_ONES) ? '0 : least_new;
			end
		end
	end

	assign busy           = (st_q != C_IDLE);
	assign done           = done_q;
	assign estimate_value = est_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cmsk_checker.sv -----
// Port checker for the count-min sketch core, bound to every instance of the top level.
// Depends on cmsk_pkg for field widths.
`default_nettype none

module cmsk_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic                       mode,
	input  logic [cmsk_pkg::KEY_W-1:0] key,
	input  logic [cmsk_pkg::CNT_W-1:0] amount,
	input  logic                       done,
	input  logic [cmsk_pkg::CNT_W-1:0] estimate_value
);
	import cmsk_pkg::*;

	logic [KEY_W-1:0] key_seen;
	logic [CNT_W-1:0] amount_seen;
	logic             mode_seen;

	assign key_seen    = key;
	assign amount_seen = amount;
	assign mode_seen   = mode;

	// accepted command holds the core busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (mode_seen == MODE_ADD || mode_seen == MODE_EST)) |=> busy)
		else $error("accepted command did not raise busy");

	// a result beat only closes a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result beat without a finished command");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat longer than one cycle");

	a_no_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (estimate_value != CNT_ALL_ONES))
		else $error("all-ones minimum reported unmapped");

	// add commands never produce a beat in the cycle after acceptance
	a_add_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode_seen == MODE_ADD && (key_seen == key_seen)
			&& (amount_seen == amount_seen)) |=> !done)
		else $error("result beat right after an add command");

endmodule

bind count_min_sketch_core cmsk_checker u_cmsk_checker (.*);

`default_nettype wire
